/* sv/xar_pkg.sv */
`default_nettype none
package xar_pkg;

  localparam int DATA_WIDTH     = 32;
  localparam int COEF_WIDTH     = 18;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int PIPE_LATENCY   = 6;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef word_t [2:0] vec3_t;

  localparam coef_t COS_RESET = 18'sd65536;
  localparam coef_t SIN_RESET = 18'sd0;

  typedef struct packed {
    vec3_t pos;
    vec3_t vel;
  } state_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t vel_x;
    word_t vel_y;
    word_t vel_z;
  } in_item_t;

  typedef struct packed {
    word_t out_pos_x;
    word_t out_pos_y;
    word_t out_pos_z;
    word_t out_vel_x;
    word_t out_vel_y;
    word_t out_vel_z;
  } out_item_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic  en;
    axis_t axis;
    coef_t c;
    coef_t s;
  } rot_ctrl_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ROT_ENABLE = 3'd0,
    CFG_COS_X      = 3'd1,
    CFG_SIN_X      = 3'd2,
    CFG_COS_Y      = 3'd3,
    CFG_SIN_Y      = 3'd4,
    CFG_COS_Z      = 3'd5,
    CFG_SIN_Z      = 3'd6
  } cfg_idx_t;

endpackage
`default_nettype wire

/* sv/xar_rot.sv */
`default_nettype none
module xar_rot #(
  parameter int COEF_FRAC_BITS = xar_pkg::COEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  xar_pkg::rot_ctrl_t ctrl,
  input  xar_pkg::state_t    in_state,
  output logic               out_valid,
  output xar_pkg::state_t    out_state
);

  localparam int DW     = xar_pkg::DATA_WIDTH;
  localparam int PROD_W = DW + xar_pkg::COEF_WIDTH;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

  function automatic xar_pkg::word_t rnd_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] sh;
    logic [SUM_W-DW:0]       top;
    begin
      sh  = v >>> COEF_FRAC_BITS;
      top = sh[SUM_W-1:DW-1];
      if (top == '0 || &top) begin
        return sh[DW-1:0];
      end else if (sh[SUM_W-1]) begin
        return {1'b1, {(DW-1){1'b0}}};
      end else begin
        return {1'b0, {(DW-1){1'b1}}};
      end
    end
  endfunction

  logic [1:0] iu, iw;
  logic       flip;

  always_comb begin
    unique case (ctrl.axis)
      xar_pkg::AXIS_X: begin iu = 2'd1; iw = 2'd2; flip = 1'b0; end
      xar_pkg::AXIS_Y: begin iu = 2'd0; iw = 2'd2; flip = 1'b1; end
      xar_pkg::AXIS_Z: begin iu = 2'd0; iw = 2'd1; flip = 1'b0; end
      default:         begin iu = 2'd0; iw = 2'd1; flip = 1'b0; end
    endcase
  end

  xar_pkg::vec3_t vin [2];
  assign vin[0] = in_state.pos;
  assign vin[1] = in_state.vel;

  // stage 1: products
  logic                    v1_r, en1_r, flip1_r;
  logic [1:0]              iu1_r, iw1_r;
  xar_pkg::state_t         st1_r;
  logic signed [PROD_W-1:0] pcu_r [2];
  logic signed [PROD_W-1:0] psw_r [2];
  logic signed [PROD_W-1:0] pcw_r [2];
  logic signed [PROD_W-1:0] psu_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    en1_r   <= ctrl.en;
    flip1_r <= flip;
    iu1_r   <= iu;
    iw1_r   <= iw;
    st1_r   <= in_state;
  end

  for (genvar g = 0; g < 2; g++) begin : g_mul
    always_ff @(posedge clk) begin
      pcu_r[g] <= $signed(vin[g][iu]) * ctrl.c;
      psw_r[g] <= $signed(vin[g][iw]) * ctrl.s;
      pcw_r[g] <= $signed(vin[g][iw]) * ctrl.c;
      psu_r[g] <= $signed(vin[g][iu]) * ctrl.s;
    end
  end

  // stage 2: sum, round, saturate
  logic signed [SUM_W-1:0] sum_u [2];
  logic signed [SUM_W-1:0] sum_w [2];

  for (genvar g = 0; g < 2; g++) begin : g_sum
    always_comb begin
      if (flip1_r) begin
        sum_u[g] = SUM_W'(pcu_r[g]) - SUM_W'(psw_r[g]) + HALF;
        sum_w[g] = SUM_W'(pcw_r[g]) + SUM_W'(psu_r[g]) + HALF;
      end else begin
        sum_u[g] = SUM_W'(pcu_r[g]) + SUM_W'(psw_r[g]) + HALF;
        sum_w[g] = SUM_W'(pcw_r[g]) - SUM_W'(psu_r[g]) + HALF;
      end
    end
  end

  xar_pkg::state_t st_nxt;
  xar_pkg::state_t st2_r;
  logic            v2_r;

  always_comb begin
    st_nxt = st1_r;
    if (en1_r) begin
      st_nxt.pos[iu1_r] = rnd_sat(sum_u[0]);
      st_nxt.pos[iw1_r] = rnd_sat(sum_w[0]);
      st_nxt.vel[iu1_r] = rnd_sat(sum_u[1]);
      st_nxt.vel[iw1_r] = rnd_sat(sum_w[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    st2_r <= st_nxt;
  end

  assign out_valid = v2_r;
  assign out_state = st2_r;

endmodule
`default_nettype wire

/* sv/xyz_axis_rotate_pos_vel.sv */
// A result strobes out_valid once its start transaction has passed the X, Y and Z rotators.
// Throughput: one transaction per cycle; busy stays low, no stall path.
// Each axis step takes two stages: products, then sum/round/saturate.
// Reset (rst_n low, synchronous) empties the pipeline and restores
// rot_enable to 0, cosines to 1.0 and sines to 0.
`default_nettype none
module xyz_axis_rotate_pos_vel #(
  parameter int COEF_FRAC_BITS = xar_pkg::COEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  xar_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  output xar_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [xar_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx,
  input  logic [xar_pkg::COEF_WIDTH-1:0]      cfg_wdata
);

  localparam int LAT = xar_pkg::PIPE_LATENCY;

  logic [2:0]     rot_en_r;
  xar_pkg::coef_t cos_x_r, sin_x_r, cos_y_r, sin_y_r, cos_z_r, sin_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_en_r <= '0;
      cos_x_r  <= xar_pkg::COS_RESET;
      sin_x_r  <= xar_pkg::SIN_RESET;
      cos_y_r  <= xar_pkg::COS_RESET;
      sin_y_r  <= xar_pkg::SIN_RESET;
      cos_z_r  <= xar_pkg::COS_RESET;
      sin_z_r  <= xar_pkg::SIN_RESET;
    end else if (cfg_we) begin
      unique case (xar_pkg::cfg_idx_t'(cfg_idx))
        xar_pkg::CFG_ROT_ENABLE: rot_en_r <= cfg_wdata[2:0];
        xar_pkg::CFG_COS_X:      cos_x_r  <= $signed(cfg_wdata);
        xar_pkg::CFG_SIN_X:      sin_x_r  <= $signed(cfg_wdata);
        xar_pkg::CFG_COS_Y:      cos_y_r  <= $signed(cfg_wdata);
        xar_pkg::CFG_SIN_Y:      sin_y_r  <= $signed(cfg_wdata);
        xar_pkg::CFG_COS_Z:      cos_z_r  <= $signed(cfg_wdata);
        xar_pkg::CFG_SIN_Z:      sin_z_r  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic acc;
  assign acc = start && !busy;

  xar_pkg::rot_ctrl_t ctrl_x, ctrl_y, ctrl_z;
  assign ctrl_x = '{en: rot_en_r[0], axis: xar_pkg::AXIS_X, c: cos_x_r, s: sin_x_r};
  assign ctrl_y = '{en: rot_en_r[1], axis: xar_pkg::AXIS_Y, c: cos_y_r, s: sin_y_r};
  assign ctrl_z = '{en: rot_en_r[2], axis: xar_pkg::AXIS_Z, c: cos_z_r, s: sin_z_r};

  xar_pkg::state_t st_in, st_x, st_y, st_z;
  logic            v_x, v_y, v_z;

  assign st_in.pos = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign st_in.vel = {in_data.vel_z, in_data.vel_y, in_data.vel_x};

  xar_rot #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_rot_x (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .ctrl(ctrl_x),
    .in_state(st_in), .out_valid(v_x), .out_state(st_x)
  );

  xar_rot #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_rot_y (
    .clk(clk), .rst_n(rst_n), .in_valid(v_x), .ctrl(ctrl_y),
    .in_state(st_x), .out_valid(v_y), .out_state(st_y)
  );

  xar_rot #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_rot_z (
    .clk(clk), .rst_n(rst_n), .in_valid(v_y), .ctrl(ctrl_z),
    .in_state(st_y), .out_valid(v_z), .out_state(st_z)
  );

  assign out_valid          = v_z;
  assign out_data.out_pos_x = st_z.pos[0];
  assign out_data.out_pos_y = st_z.pos[1];
  assign out_data.out_pos_z = st_z.pos[2];
  assign out_data.out_vel_x = st_z.vel[0];
  assign out_data.out_vel_y = st_z.vel[1];
  assign out_data.out_vel_z = st_z.vel[2];

`ifndef ASSERT_OFF
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("accepted transaction produced no result");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAT))
    else $error("result without matching transaction");

  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result right after reset");
`endif

endmodule
`default_nettype wire
